[hdl/ttok_pkg.sv]
`timescale 1ns / 1ps

package ttok_pkg;

    localparam int POSITION_BITS = 16;
    localparam int FIELD_BITS    = 16;

    // Token queue depth; must be a power of two so the pointers wrap naturally.
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_VT      = 8'h0B;
    localparam logic [7:0] CHAR_FF      = 8'h0C;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_QUOTE   = 8'h22;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    typedef enum logic [2:0] {
        KIND_END    = 3'd0,
        KIND_STOP   = 3'd1,
        KIND_IDENT  = 3'd2,
        KIND_NUMBER = 3'd3,
        KIND_STRING = 3'd4
    } token_kind_t;

    typedef struct packed {
        token_kind_t           kind;
        logic [FIELD_BITS-1:0] offset;
        logic [FIELD_BITS-1:0] length;
        logic                  unterminated;
        logic                  last_of_run;
    } token_t;

    // Up to two tokens written into the queue in one cycle, oldest first.
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } token_push_t;

    function automatic logic is_blank(input logic [7:0] b);
        return b inside {CHAR_SPACE, CHAR_TAB, CHAR_VT, CHAR_FF, CHAR_LF, CHAR_CR};
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return b inside {[CHAR_LOWER_A:CHAR_LOWER_Z], [CHAR_UPPER_A:CHAR_UPPER_Z]};
    endfunction

    function automatic logic is_numeral(input logic [7:0] b);
        return b inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]};
    endfunction

endpackage

[hdl/ttok_scanner.sv]
`timescale 1ns / 1ps

module ttok_scanner #(
    parameter int POSITION_BITS = ttok_pkg::POSITION_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fire,
    input  logic [7:0]              char_byte,
    output ttok_pkg::token_push_t   push
);

    localparam int FB = ttok_pkg::FIELD_BITS;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_STRING
    } mode_t;

    mode_t                    mode_reg, mode_next, mode_mid, mode_new;
    logic [POSITION_BITS-1:0] pos_reg, pos_next, pos_inc;
    logic [POSITION_BITS-1:0] begin_reg, begin_next, begin_new;
    logic [POSITION_BITS-1:0] run;
    logic                     taken;
    logic                     close_valid, fresh_valid;
    ttok_pkg::token_t         close_tok, fresh_tok;
    logic                     is_nul;

    // Clamp a position-wide value to the reported field width.
    function automatic logic [FB-1:0] sat_field(input logic [POSITION_BITS-1:0] v);
        logic [POSITION_BITS+FB-1:0] ext;
        ext = {{FB{1'b0}}, v};
        return (|ext[POSITION_BITS+FB-1:FB]) ? {FB{1'b1}} : ext[FB-1:0];
    endfunction

    always_comb
    begin
        is_nul  = (char_byte == ttok_pkg::CHAR_NUL);
        run     = (pos_reg >= begin_reg) ? pos_reg - begin_reg : '0;
        pos_inc = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

        // Token closed by this byte out of the open run, if any.
        taken                  = 1'b0;
        mode_mid               = mode_reg;
        close_valid            = 1'b0;
        close_tok.kind         = ttok_pkg::KIND_STRING;
        close_tok.offset       = sat_field(begin_reg);
        close_tok.length       = sat_field(run);
        close_tok.unterminated = 1'b0;
        close_tok.last_of_run  = 1'b0;
        case (mode_reg)
            MODE_STRING:
            begin
                if (char_byte == ttok_pkg::CHAR_QUOTE)
                begin
                    close_valid = 1'b1;
                    mode_mid    = MODE_IDLE;
                    taken       = 1'b1;
                end
                else if (is_nul)
                begin
                    close_valid            = 1'b1;
                    close_tok.unterminated = 1'b1;
                    mode_mid               = MODE_IDLE;
                end
                else
                begin
                    taken = 1'b1;
                end
            end
            MODE_IDENT:
            begin
                if (ttok_pkg::is_letter(char_byte))
                begin
                    taken = 1'b1;
                end
                else
                begin
                    close_valid    = 1'b1;
                    close_tok.kind = ttok_pkg::KIND_IDENT;
                    mode_mid       = MODE_IDLE;
                end
            end
            MODE_NUMBER:
            begin
                if (ttok_pkg::is_numeral(char_byte))
                begin
                    taken = 1'b1;
                end
                else
                begin
                    close_valid    = 1'b1;
                    close_tok.kind = ttok_pkg::KIND_NUMBER;
                    mode_mid       = MODE_IDLE;
                end
            end
            default:
            begin
                mode_mid = MODE_IDLE;
            end
        endcase

        // A byte not absorbed by the open run is classified on its own.
        mode_new               = mode_mid;
        begin_new              = begin_reg;
        fresh_valid            = 1'b0;
        fresh_tok.kind         = ttok_pkg::KIND_IDENT;
        fresh_tok.offset       = sat_field(pos_reg);
        fresh_tok.length       = FB'(1);
        fresh_tok.unterminated = 1'b0;
        fresh_tok.last_of_run  = 1'b0;
        if (!taken)
        begin
            if (is_nul)
            begin
                fresh_valid      = 1'b1;
                fresh_tok.kind   = ttok_pkg::KIND_END;
                fresh_tok.length = '0;
            end
            else if (ttok_pkg::is_blank(char_byte))
            begin
                fresh_valid = 1'b0;
            end
            else if (char_byte == ttok_pkg::CHAR_DOT)
            begin
                fresh_valid    = 1'b1;
                fresh_tok.kind = ttok_pkg::KIND_STOP;
            end
            else if (ttok_pkg::is_letter(char_byte))
            begin
                mode_new  = MODE_IDENT;
                begin_new = pos_reg;
            end
            else if (ttok_pkg::is_numeral(char_byte))
            begin
                mode_new  = MODE_NUMBER;
                begin_new = pos_reg;
            end
            else if (char_byte == ttok_pkg::CHAR_QUOTE)
            begin
                // String content starts after the opening quote.
                mode_new  = MODE_STRING;
                begin_new = pos_inc;
            end
            else
            begin
                fresh_valid = 1'b1;
            end
        end

        if (is_nul)
        begin
            mode_next  = MODE_IDLE;
            pos_next   = '0;
            begin_next = '0;
        end
        else
        begin
            mode_next  = mode_new;
            pos_next   = pos_inc;
            begin_next = begin_new;
        end

        // Pack the tokens oldest first and mark the last one of this byte.
        push.second             = fresh_tok;
        push.second.last_of_run = 1'b1;
        if (close_valid)
        begin
            push.first             = close_tok;
            push.first.last_of_run = !fresh_valid;
        end
        else
        begin
            push.first             = fresh_tok;
            push.first.last_of_run = 1'b1;
        end
        if (fire)
        begin
            push.count = {1'b0, close_valid} + {1'b0, fresh_valid};
        end
        else
        begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            begin_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
        end
    end

endmodule

[hdl/ttok_queue.sv]
`timescale 1ns / 1ps

module ttok_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ttok_pkg::token_push_t push,
    output logic                  room,
    output logic [$clog2(ttok_pkg::QUEUE_DEPTH+1)-1:0] level,
    output logic                  out_valid,
    input  logic                  out_stall,
    output ttok_pkg::token_t      head_tok
);

    localparam int DEPTH = ttok_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ttok_pkg::token_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]   head_reg, head_next, tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    always_comb
    begin
        pop        = (count_reg != '0) && !out_stall;
        room       = (count_reg <= CNT_W'(DEPTH - 2));
        count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);
        tail_next  = tail_reg + PTR_W'(push.count);
        head_next  = head_reg + PTR_W'(pop);
        out_valid  = (count_reg != '0);
        head_tok   = entry_reg[head_reg];
        level      = count_reg;
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[tail_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[tail_reg + PTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

[hdl/text_tokenizer.sv]
`timescale 1ns / 1ps

// Byte-serial tokenizer: one text byte per word in, one token per word out. A byte is
// held in an input register, classified combinationally against the open token and
// the tokens it closes are written into a four-entry token queue that drives the output
// port. Bytes are taken at one per cycle as long as each closes at most one token and
// the output is not stalled; the output port delivers one token per cycle when not
// stalled, so a byte that closes two tokens (a run ended by a full stop, another symbol
// or the end byte) fills the queue faster than it drains. Byte 0 ends the text, emits
// an end token and restarts the position count at 0.
module text_tokenizer #(
    parameter int POSITION_BITS = ttok_pkg::POSITION_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  token_kind,
    output logic [15:0] token_offset,
    output logic [15:0] token_length,
    output logic        unterminated,
    output logic        last_of_run
);

    localparam int CNT_W = $clog2(ttok_pkg::QUEUE_DEPTH + 1);

    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            byte_reg;
    logic                  room;
    logic                  scan_fire;
    logic                  in_accept;
    logic [CNT_W-1:0]      level;
    ttok_pkg::token_push_t push;
    ttok_pkg::token_t      head_tok;

    always_comb
    begin
        scan_fire = in_valid_reg && room;
        in_stall  = in_valid_reg && !room;
        in_accept = in_valid && !in_stall;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (scan_fire)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg <= char_byte;
        end
    end

    ttok_scanner #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scanner (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (scan_fire),
        .char_byte (byte_reg),
        .push      (push)
    );

    ttok_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .level     (level),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head_tok  (head_tok)
    );

    assign token_kind   = head_tok.kind;
    assign token_offset = head_tok.offset;
    assign token_length = head_tok.length;
    assign unterminated = head_tok.unterminated;
    assign last_of_run  = head_tok.last_of_run;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= CNT_W'(ttok_pkg::QUEUE_DEPTH))
        else $error("token queue overfilled");

    a_pair_marks: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> !push.first.last_of_run && push.second.last_of_run)
        else $error("last_of_run misplaced on a two-token byte");

    a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
        scan_fire && byte_reg == ttok_pkg::CHAR_NUL |->
            (push.count == 2'd1 && push.first.kind == ttok_pkg::KIND_END) ||
            (push.count == 2'd2 && push.second.kind == ttok_pkg::KIND_END))
        else $error("end byte did not finish with an end token");

    a_fire_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> in_valid_reg)
        else $error("tokens pushed without a held byte");

endmodule

[test/token_checker.sv]
`timescale 1ns / 1ps

module token_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  char_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  token_kind,
    input  logic [15:0] token_offset,
    input  logic [15:0] token_length,
    input  logic        unterminated,
    input  logic        last_of_run,
    output int          mismatches,
    output int          tokens_owed
);

    typedef enum logic [1:0] {
        SCAN_IDLE   = 2'd0,
        SCAN_IDENT  = 2'd1,
        SCAN_NUMBER = 2'd2,
        SCAN_STRING = 2'd3
    } scan_mode_t;

    typedef logic [ttok_pkg::POSITION_BITS-1:0] position_t;

    localparam position_t       POSITION_MAX = '1;
    localparam longint unsigned FIELD_MAX    = (64'd1 << ttok_pkg::FIELD_BITS) - 1;

    scan_mode_t       mode      = SCAN_IDLE;
    position_t        char_pos  = '0;
    position_t        tok_begin = '0;
    ttok_pkg::token_t pending_tokens [$];
    ttok_pkg::token_t oldest;
    int               mismatch_count = 0;

    initial
    begin
        mismatches  = 0;
        tokens_owed = 0;
    end

    function automatic logic char_is_letter(input logic [7:0] b);
        return (b >= ttok_pkg::CHAR_LOWER_A && b <= ttok_pkg::CHAR_LOWER_Z) ||
               (b >= ttok_pkg::CHAR_UPPER_A && b <= ttok_pkg::CHAR_UPPER_Z);
    endfunction

    function automatic logic char_is_numeral(input logic [7:0] b);
        return b >= ttok_pkg::CHAR_DIGIT_0 && b <= ttok_pkg::CHAR_DIGIT_9;
    endfunction

    function automatic logic char_is_blank(input logic [7:0] b);
        return b == ttok_pkg::CHAR_SPACE || b == ttok_pkg::CHAR_TAB ||
               b == ttok_pkg::CHAR_VT || b == ttok_pkg::CHAR_FF ||
               b == ttok_pkg::CHAR_LF || b == ttok_pkg::CHAR_CR;
    endfunction

    // Offsets and lengths wider than the output port are clipped to all ones.
    function automatic logic [ttok_pkg::FIELD_BITS-1:0] to_field(input position_t v);
        longint unsigned wide;
        wide = v;
        return (wide > FIELD_MAX) ? '1 : wide[ttok_pkg::FIELD_BITS-1:0];
    endfunction

    function automatic position_t step_pos(input position_t p);
        return (p == POSITION_MAX) ? p : position_t'(p + 1'b1);
    endfunction

    function automatic ttok_pkg::token_t make_token(input ttok_pkg::token_kind_t kind,
                                                    input position_t off,
                                                    input position_t len,
                                                    input logic open_end);
        ttok_pkg::token_t t;
        t.kind         = kind;
        t.offset       = to_field(off);
        t.length       = to_field(len);
        t.unterminated = open_end;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    // Advances the scanner by one byte and queues the tokens that the byte closes.
    function void scan_byte(input logic [7:0] b);
        ttok_pkg::token_t found [2];
        int               n;
        logic             taken;
        position_t        p;
        position_t        run;
        p     = char_pos;
        run   = (p >= tok_begin) ? position_t'(p - tok_begin) : '0;
        n     = 0;
        taken = 1'b0;
        case (mode)
            SCAN_STRING:
            begin
                if (b == ttok_pkg::CHAR_QUOTE)
                begin
                    found[n] = make_token(ttok_pkg::KIND_STRING, tok_begin, run, 1'b0);
                    n++;
                    mode  = SCAN_IDLE;
                    taken = 1'b1;
                end
                else if (b == ttok_pkg::CHAR_NUL)
                begin
                    found[n] = make_token(ttok_pkg::KIND_STRING, tok_begin, run, 1'b1);
                    n++;
                    mode = SCAN_IDLE;
                end
                else
                    taken = 1'b1;
            end
            SCAN_IDENT:
            begin
                if (char_is_letter(b))
                    taken = 1'b1;
                else
                begin
                    found[n] = make_token(ttok_pkg::KIND_IDENT, tok_begin, run, 1'b0);
                    n++;
                    mode = SCAN_IDLE;
                end
            end
            SCAN_NUMBER:
            begin
                if (char_is_numeral(b))
                    taken = 1'b1;
                else
                begin
                    found[n] = make_token(ttok_pkg::KIND_NUMBER, tok_begin, run, 1'b0);
                    n++;
                    mode = SCAN_IDLE;
                end
            end
            default:
                mode = SCAN_IDLE;
        endcase

        // A byte that did not extend the open token starts something of its own.
        if (!taken)
        begin
            if (b == ttok_pkg::CHAR_NUL)
            begin
                found[n] = make_token(ttok_pkg::KIND_END, p, '0, 1'b0);
                n++;
            end
            else if (char_is_blank(b))
            begin
            end
            else if (b == ttok_pkg::CHAR_DOT)
            begin
                found[n] = make_token(ttok_pkg::KIND_STOP, p, position_t'(1), 1'b0);
                n++;
            end
            else if (char_is_letter(b))
            begin
                mode      = SCAN_IDENT;
                tok_begin = p;
            end
            else if (char_is_numeral(b))
            begin
                mode      = SCAN_NUMBER;
                tok_begin = p;
            end
            else if (b == ttok_pkg::CHAR_QUOTE)
            begin
                mode      = SCAN_STRING;
                tok_begin = step_pos(p);
            end
            else
            begin
                found[n] = make_token(ttok_pkg::KIND_IDENT, p, position_t'(1), 1'b0);
                n++;
            end
        end

        if (n > 0)
            found[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            pending_tokens.push_back(found[i]);

        if (b == ttok_pkg::CHAR_NUL)
        begin
            char_pos  = '0;
            tok_begin = '0;
            mode      = SCAN_IDLE;
        end
        else
            char_pos = step_pos(p);
    endfunction

    function void check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: token %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode      = SCAN_IDLE;
            char_pos  = '0;
            tok_begin = '0;
            pending_tokens.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                scan_byte(char_byte);
            if (out_valid && !out_stall)
            begin
                if (pending_tokens.size() == 0)
                begin
                    $display("%0t: token expected none actual kind %0d offset %0d length %0d",
                             $time, token_kind, token_offset, token_length);
                    mismatch_count++;
                end
                else
                begin
                    oldest = pending_tokens.pop_front();
                    check_field("kind", oldest.kind, token_kind);
                    check_field("offset", oldest.offset, token_offset);
                    check_field("length", oldest.length, token_length);
                    check_field("unterminated", oldest.unterminated, unterminated);
                    check_field("last_of_run", oldest.last_of_run, last_of_run);
                end
            end
            mismatches  <= mismatch_count;
            tokens_owed <= pending_tokens.size();
        end
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_BYTES   = 400;
    localparam int SQUEEZE_AFTER  = 100;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int TAIL_CYCLES    = 10;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  char_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  token_kind;
    logic [15:0] token_offset;
    logic [15:0] token_length;
    logic        unterminated;
    logic        last_of_run;
    int          mismatches;
    int          tokens_owed;

    logic        squeeze     = 1'b0;
    bit          sender_calm = 1'b0;
    int          bytes_sent  = 0;

    text_tokenizer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_byte    (char_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .token_offset (token_offset),
        .token_length (token_length),
        .unterminated (unterminated),
        .last_of_run  (last_of_run)
    );

    token_checker token_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_byte    (char_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .token_offset (token_offset),
        .token_length (token_length),
        .unterminated (unterminated),
        .last_of_run  (last_of_run),
        .mismatches   (mismatches),
        .tokens_owed  (tokens_owed)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1500000;
        $display("text_tokenizer regression: fail");
        $finish;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int sender_gap();
        if (sender_calm || $urandom_range(0, 3) != 0)
            return 0;
        return pick_gap();
    endfunction

    function automatic logic [7:0] random_letter();
        if ($urandom_range(0, 1) == 0)
            return 8'(ttok_pkg::CHAR_UPPER_A + $urandom_range(0, 25));
        return 8'(ttok_pkg::CHAR_LOWER_A + $urandom_range(0, 25));
    endfunction

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Mostly well-formed lexemes with random content, the rest raw noise or an end byte.
    task automatic send_phrase();
        int         pick;
        int         len;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            len = $urandom_range(1, 8);
            repeat (len) send_byte(random_letter());
        end
        else if (pick < 40)
        begin
            len = $urandom_range(1, 6);
            repeat (len) send_byte(8'(ttok_pkg::CHAR_DIGIT_0 + $urandom_range(0, 9)));
        end
        else if (pick < 55)
        begin
            send_byte(ttok_pkg::CHAR_QUOTE);
            len = $urandom_range(0, 6);
            repeat (len)
            begin
                do
                begin
                    b = 8'($urandom_range(1, 255));
                end
                while (b == ttok_pkg::CHAR_QUOTE);
                send_byte(b);
            end
            send_byte(($urandom_range(0, 9) == 0) ? ttok_pkg::CHAR_NUL : ttok_pkg::CHAR_QUOTE);
        end
        else if (pick < 65)
            send_byte(ttok_pkg::CHAR_DOT);
        else if (pick < 75)
        begin
            case ($urandom_range(0, 5))
                0: b = ttok_pkg::CHAR_SPACE;
                1: b = ttok_pkg::CHAR_TAB;
                2: b = ttok_pkg::CHAR_VT;
                3: b = ttok_pkg::CHAR_FF;
                4: b = ttok_pkg::CHAR_LF;
                default: b = ttok_pkg::CHAR_CR;
            endcase
            send_byte(b);
        end
        else if (pick < 90)
            send_byte(8'($urandom_range(0, 255)));
        else
            send_byte(ttok_pkg::CHAR_NUL);
    endtask

    initial
    begin
        int stall_left;
        int cycles;
        bit calm;
        bit squeezed;
        stall_left = 0;
        cycles     = 0;
        calm       = 1'b0;
        squeezed   = 1'b0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles % 256 == 0)
                calm = ($urandom_range(0, 2) == 0);
            if (squeeze && !squeezed)
            begin
                // Hold the output long enough for the token queue to back up.
                squeezed = 1'b1;
                out_stall <= 1'b1;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap() - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        int drain_cycles;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Runs closed by a full stop, a symbol and the end byte, empty and
        // unterminated strings, a tab inside a string and every other blank.
        send_text("Az.09 \"\"\"\tq\"Z#");
        send_byte(8'hFF);
        send_byte(ttok_pkg::CHAR_VT);
        send_byte(ttok_pkg::CHAR_FF);
        send_byte(ttok_pkg::CHAR_CR);
        send_byte(ttok_pkg::CHAR_LF);
        send_text("a");
        send_byte(ttok_pkg::CHAR_NUL);
        send_text("\"x");
        send_byte(ttok_pkg::CHAR_NUL);
        send_byte(ttok_pkg::CHAR_NUL);
        send_text("7");
        send_byte(ttok_pkg::CHAR_NUL);

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 15) == 0)
                sender_calm = !sender_calm;
            if (bytes_sent >= SQUEEZE_AFTER && !squeeze)
            begin
                squeeze <= 1'b1;
                sender_calm = 1'b1;
            end
            send_phrase();
        end
        send_byte(ttok_pkg::CHAR_NUL);

        // A stop, a short string and an empty string left open at the end byte.
        sender_calm = 1'b1;
        send_text(".\"b\"\"");
        send_byte(ttok_pkg::CHAR_NUL);
        in_valid <= 1'b0;

        drain_cycles = 0;
        do
        begin
            @(posedge clk);
            drain_cycles++;
        end
        while (tokens_owed != 0 && drain_cycles < DRAIN_LIMIT);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (tokens_owed != 0)
            $display("%0t: %0d expected tokens never arrived", $time, tokens_owed);
        if (mismatches == 0 && tokens_owed == 0)
            $display("text_tokenizer regression: pass");
        else
            $display("text_tokenizer regression: fail");
        $finish;
    end

endmodule

[files.f]
hdl/ttok_pkg.sv
hdl/ttok_scanner.sv
hdl/ttok_queue.sv
hdl/text_tokenizer.sv
test/token_checker.sv
test/tb_top.sv
